@@ design/psa_pkg.sv @@
`default_nettype none
package psa_pkg;

   localparam int TAG_BITS        = 64;
   localparam int COLOR_BITS      = 24;
   localparam int ALPHA_BITS      = 17;
   localparam int OUT_COORD_BITS  = 8;
   localparam int COORD_FIELD_BITS = 20;
   localparam int X_SHIFT         = 40;
   localparam int Y_SHIFT         = 20;

   localparam logic [ALPHA_BITS-1:0] ALPHA_ONE  = 17'h10000;
   localparam logic [ALPHA_BITS-1:0] ALPHA_HALF = 17'h08000;

   // per-lane handshake with the averaging lanes
   typedef struct packed {
      logic start;
   } lane_cmd_type;

   typedef struct packed {
      logic busy;
   } lane_status_type;

endpackage
`default_nettype wire

@@ design/psa_avg_lane.sv @@
`default_nettype none
module psa_avg_lane #(
   parameter int COUNT_BITS = 16,
   parameter int VAL_BITS   = 24
) (
   input  wire                      clock,
   input  wire                      reset,
   input  psa_pkg::lane_cmd_type    cmd,
   input  wire  [VAL_BITS-1:0]      old_val,
   input  wire  [VAL_BITS-1:0]      in_val,
   input  wire  [COUNT_BITS-1:0]    count,
   output psa_pkg::lane_status_type status,
   output logic [VAL_BITS-1:0]      result
);
   import psa_pkg::*;

   localparam int NUM_BITS  = VAL_BITS + COUNT_BITS + 1;
   localparam int REM_BITS  = COUNT_BITS + 1;
   localparam int STEP_MAX  = (COUNT_BITS > VAL_BITS) ? COUNT_BITS : VAL_BITS;
   localparam int STEP_BITS = $clog2(STEP_MAX + 1);

   logic                  busy_ff, busy_in;
   logic                  div_ff, div_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [NUM_BITS-1:0]   mcand_ff, mcand_in;
   logic [NUM_BITS-1:0]   acc_ff, acc_in;
   logic [COUNT_BITS-1:0] mult_ff, mult_in;
   logic [REM_BITS-1:0]   dsr_ff, dsr_in;
   logic [REM_BITS-1:0]   rem_ff, rem_in;
   logic [VAL_BITS-1:0]   quo_ff, quo_in;
   logic [NUM_BITS-1:0]   acc_sum;
   logic [REM_BITS:0]     trial;
   logic [REM_BITS:0]     trial_diff;

   always_comb begin
      acc_sum    = acc_ff + (mult_ff[0] ? mcand_ff : '0);
      trial      = {rem_ff, quo_ff[VAL_BITS-1]};
      trial_diff = trial - {1'b0, dsr_ff};
      busy_in  = busy_ff;
      div_in   = div_ff;
      step_in  = step_ff;
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      mult_in  = mult_ff;
      dsr_in   = dsr_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         div_in   = 1'b0;
         step_in  = '0;
         acc_in   = NUM_BITS'(in_val);
         mcand_in = NUM_BITS'(old_val);
         mult_in  = count;
         dsr_in   = REM_BITS'(count) + REM_BITS'(1);
      end else if (busy_ff && !div_ff) begin
         // shift-add multiply, one bit of n per cycle
         acc_in   = acc_sum;
         mcand_in = mcand_ff << 1;
         mult_in  = mult_ff >> 1;
         step_in  = step_ff + STEP_BITS'(1);
         if (step_ff == STEP_BITS'(COUNT_BITS - 1)) begin
            // quotient fits in VAL_BITS, so the high part is already below n+1
            div_in  = 1'b1;
            step_in = '0;
            rem_in  = acc_sum[NUM_BITS-1:VAL_BITS];
            quo_in  = acc_sum[VAL_BITS-1:0];
         end
      end else if (busy_ff) begin
         // restoring divide, one quotient bit per cycle
         if (!trial_diff[REM_BITS]) begin
            rem_in = trial_diff[REM_BITS-1:0];
            quo_in = {quo_ff[VAL_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[REM_BITS-1:0];
            quo_in = {quo_ff[VAL_BITS-2:0], 1'b0};
         end
         step_in = step_ff + STEP_BITS'(1);
         if (step_ff == STEP_BITS'(VAL_BITS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         div_ff  <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         div_ff  <= div_in;
         step_ff <= step_in;
      end
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
      mult_ff  <= mult_in;
      dsr_ff   <= dsr_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
   end

   assign status.busy = busy_ff;
   assign result      = quo_ff;

endmodule
`default_nettype wire

@@ design/psa_pixel_mem.sv @@
`default_nettype none
module psa_pixel_mem #(
   parameter int ADDR_BITS = 16,
   parameter int DATA_BITS = 106
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  rd_en,
   input  wire  [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data,
   input  wire                  wr_en,
   input  wire  [ADDR_BITS-1:0] wr_addr,
   input  wire  [DATA_BITS-1:0] wr_data,
   output logic                 clearing
);
   import psa_pkg::*;

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;
   logic                 clear_ff, clear_in;
   logic [ADDR_BITS-1:0] clear_addr_ff, clear_addr_in;
   logic                 mem_we;
   logic [ADDR_BITS-1:0] mem_waddr;
   logic [DATA_BITS-1:0] mem_wdata;

   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + ADDR_BITS'(1);
         if (clear_addr_ff == '1) begin
            clear_in = 1'b0;
         end
      end
      mem_we    = clear_ff || wr_en;
      mem_waddr = clear_ff ? clear_addr_ff : wr_addr;
      mem_wdata = clear_ff ? '0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clear_ff;

endmodule
`default_nettype wire

@@ design/pixel_sample_accumulator_top.sv @@
// an accepted transaction reads its pixel entry, then the lanes run the bit-serial multiply
//   (one bit of the count per cycle) followed by the divide, and the entry is written back;
//   req_stall stays high until then, longer while a result is stalled
// reset: synchronous; the pixel store is then swept to zero, one entry per cycle,
//   over all 2^(X_BITS+Y_BITS) entries, with req_stall high throughout
`default_nettype none
module pixel_sample_accumulator_top #(
   parameter int X_BITS     = 8,
   parameter int Y_BITS     = 8,
   parameter int COUNT_BITS = 16
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_wr_en,
   input  wire                                   csr_wr_data,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [psa_pkg::TAG_BITS-1:0]          req_ray_tag,
   input  wire  [psa_pkg::COLOR_BITS-1:0]        req_in_red,
   input  wire  [psa_pkg::COLOR_BITS-1:0]        req_in_green,
   input  wire  [psa_pkg::COLOR_BITS-1:0]        req_in_blue,
   input  wire  [psa_pkg::ALPHA_BITS-1:0]        req_in_alpha,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [psa_pkg::OUT_COORD_BITS-1:0]    rsp_out_x,
   output logic [psa_pkg::OUT_COORD_BITS-1:0]    rsp_out_y,
   output logic [psa_pkg::COLOR_BITS-1:0]        rsp_out_red,
   output logic [psa_pkg::COLOR_BITS-1:0]        rsp_out_green,
   output logic [psa_pkg::COLOR_BITS-1:0]        rsp_out_blue,
   output logic [psa_pkg::ALPHA_BITS-1:0]        rsp_out_alpha
);
   import psa_pkg::*;

   localparam int ADDR_BITS = X_BITS + Y_BITS;
   localparam int DATA_BITS = 3 * COLOR_BITS + ALPHA_BITS + COUNT_BITS + 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_RUN   = 2'd2;
   localparam logic [1:0] S_WRITE = 2'd3;

   localparam logic [1:0] P_NORMAL = 2'd0;
   localparam logic [1:0] P_CLAIM  = 2'd1;
   localparam logic [1:0] P_ALPHA  = 2'd2;
   localparam logic [1:0] P_COUNT  = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [1:0]            path_ff, path_in;
   logic                  mode_ff;
   logic [X_BITS-1:0]     x_ff;
   logic [Y_BITS-1:0]     y_ff;
   logic [COLOR_BITS-1:0] r_ff, g_ff, b_ff;
   logic [ALPHA_BITS-1:0] a_ff;
   logic [DATA_BITS-1:0]  entry_ff, entry_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COLOR_BITS-1:0] rsp_r_ff, rsp_g_ff, rsp_b_ff;
   logic [ALPHA_BITS-1:0] rsp_a_ff;
   logic [X_BITS-1:0]     rsp_x_ff;
   logic [Y_BITS-1:0]     rsp_y_ff;

   logic [COORD_FIELD_BITS-1:0] tag_x, tag_y;
   logic                  in_range, accept;
   logic [ALPHA_BITS-1:0] a_clamp;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [DATA_BITS-1:0]  rd_data;
   logic                  clearing;
   logic                  wr_en;
   logic [DATA_BITS-1:0]  wr_data;

   logic [COLOR_BITS-1:0] rd_r, rd_g, rd_b;
   logic [ALPHA_BITS-1:0] rd_a;
   logic [COUNT_BITS-1:0] rd_n;
   logic                  rd_claim;
   logic [COLOR_BITS-1:0] old_r, old_g, old_b;
   logic [ALPHA_BITS-1:0] old_a;
   logic [COUNT_BITS-1:0] old_n, new_n;
   logic                  old_claim;
   logic [COLOR_BITS-1:0] avg_r, avg_g, avg_b;
   logic [ALPHA_BITS-1:0] avg_a, lane_a_old, lane_a_in;
   lane_cmd_type          lane_cmd;
   lane_status_type       st_r, st_g, st_b, st_a;
   logic                  lanes_busy;
   logic                  out_free;
   logic [COLOR_BITS-1:0] w_r, w_g, w_b;
   logic [ALPHA_BITS-1:0] w_a;
   logic                  w_claim;

   assign tag_x    = req_ray_tag[X_SHIFT +: COORD_FIELD_BITS];
   assign tag_y    = req_ray_tag[Y_SHIFT +: COORD_FIELD_BITS];
   assign in_range = ((tag_x >> X_BITS) == '0) && ((tag_y >> Y_BITS) == '0);
   assign a_clamp  = (req_in_alpha > ALPHA_ONE) ? ALPHA_ONE : req_in_alpha;
   assign req_stall = (state_ff != S_IDLE) || clearing;
   assign accept   = req_valid && !req_stall;
   assign rd_addr  = {tag_x[X_BITS-1:0], tag_y[Y_BITS-1:0]};

   // stored entry is {claimed, count, alpha, blue, green, red}
   assign {rd_claim, rd_n, rd_a, rd_b, rd_g, rd_r} = rd_data;
   assign {old_claim, old_n, old_a, old_b, old_g, old_r} = entry_ff;
   assign new_n = (old_n == '1) ? old_n : old_n + COUNT_BITS'(1);
   assign lanes_busy = st_r.busy || st_g.busy || st_b.busy || st_a.busy;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // the claim path computes 1.0/(n+1) as the average of zero and 1.0
   assign lane_a_old = (path_in == P_CLAIM) ? '0 : rd_a;
   assign lane_a_in  = (path_in == P_CLAIM) ? ALPHA_ONE : a_ff;

   always_comb begin
      state_in     = state_ff;
      path_in      = path_ff;
      entry_in     = entry_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      lane_cmd.start = 1'b0;
      wr_en        = 1'b0;
      w_r          = old_r;
      w_g          = old_g;
      w_b          = old_b;
      w_a          = old_a;
      w_claim      = old_claim;
      case (path_ff)
         P_NORMAL: begin
            w_r = avg_r;
            w_g = avg_g;
            w_b = avg_b;
            w_a = (avg_a > ALPHA_ONE) ? ALPHA_ONE : avg_a;
         end
         P_CLAIM: begin
            w_r     = r_ff;
            w_g     = g_ff;
            w_b     = b_ff;
            w_a     = avg_a;
            w_claim = 1'b1;
         end
         P_ALPHA: w_a = avg_a;
         default: ;
      endcase
      wr_data = {w_claim, new_n, w_a, w_b, w_g, w_r};
      case (state_ff)
         S_IDLE: begin
            if (accept && in_range) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            entry_in = rd_data;
            if (!mode_ff) begin
               path_in = P_NORMAL;
            end else if (a_ff > ALPHA_HALF && !rd_claim) begin
               path_in = P_CLAIM;
            end else if (a_ff < ALPHA_HALF && rd_claim) begin
               path_in = P_ALPHA;
            end else if (a_ff < ALPHA_HALF) begin
               path_in = P_COUNT;
            end else begin
               path_in = P_NORMAL;
            end
            state_in = S_RUN;
         end
         S_RUN: begin
            if (!lanes_busy) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (path_ff != P_NORMAL || out_free) begin
               wr_en    = 1'b1;
               state_in = S_IDLE;
               if (path_ff == P_NORMAL) begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      // lanes load straight from the read data, so they are busy from the first S_RUN cycle
      lane_cmd.start = (state_ff == S_READ);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
      path_ff  <= path_in;
      entry_ff <= entry_in;
      if (accept) begin
         x_ff <= tag_x[X_BITS-1:0];
         y_ff <= tag_y[Y_BITS-1:0];
         r_ff <= req_in_red;
         g_ff <= req_in_green;
         b_ff <= req_in_blue;
         a_ff <= a_clamp;
      end
      if (state_ff == S_WRITE && path_ff == P_NORMAL && out_free) begin
         rsp_x_ff <= x_ff;
         rsp_y_ff <= y_ff;
         rsp_r_ff <= w_r;
         rsp_g_ff <= w_g;
         rsp_b_ff <= w_b;
         rsp_a_ff <= w_a;
      end
   end

   psa_pixel_mem #(.ADDR_BITS(ADDR_BITS), .DATA_BITS(DATA_BITS)) u_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .wr_en    (wr_en),
      .wr_addr  ({x_ff, y_ff}),
      .wr_data  (wr_data),
      .clearing (clearing)
   );

   psa_avg_lane #(.COUNT_BITS(COUNT_BITS), .VAL_BITS(COLOR_BITS)) u_lane_r (
      .clock(clock), .reset(reset), .cmd(lane_cmd), .old_val(rd_r), .in_val(r_ff),
      .count(rd_n), .status(st_r), .result(avg_r)
   );

   psa_avg_lane #(.COUNT_BITS(COUNT_BITS), .VAL_BITS(COLOR_BITS)) u_lane_g (
      .clock(clock), .reset(reset), .cmd(lane_cmd), .old_val(rd_g), .in_val(g_ff),
      .count(rd_n), .status(st_g), .result(avg_g)
   );

   psa_avg_lane #(.COUNT_BITS(COUNT_BITS), .VAL_BITS(COLOR_BITS)) u_lane_b (
      .clock(clock), .reset(reset), .cmd(lane_cmd), .old_val(rd_b), .in_val(b_ff),
      .count(rd_n), .status(st_b), .result(avg_b)
   );

   psa_avg_lane #(.COUNT_BITS(COUNT_BITS), .VAL_BITS(ALPHA_BITS)) u_lane_a (
      .clock(clock), .reset(reset), .cmd(lane_cmd), .old_val(lane_a_old),
      .in_val(lane_a_in), .count(rd_n), .status(st_a), .result(avg_a)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = OUT_COORD_BITS'(rsp_x_ff);
   assign rsp_out_y     = OUT_COORD_BITS'(rsp_y_ff);
   assign rsp_out_red   = rsp_r_ff;
   assign rsp_out_green = rsp_g_ff;
   assign rsp_out_blue  = rsp_b_ff;
   assign rsp_out_alpha = rsp_a_ff;

   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      clearing |-> req_stall)
      else $error("transaction accepted during store clear");

   a_run_to_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN && !lanes_busy) |=> state_ff == S_WRITE)
      else $error("lanes finished but no write-back");

   a_rsp_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_WRITE && $past(path_ff) == P_NORMAL)
      else $error("result raised outside normal write-back");

   a_write_not_clearing: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !clearing)
      else $error("pixel write during store clear");

endmodule
`default_nettype wire

@@ tb/pixel_sample_accumulator_top_tb.sv @@
`timescale 1ns / 1ps
module pixel_sample_accumulator_top_tb;
   import psa_pkg::*;

   localparam int STORE_DEPTH = 65536;
   localparam longint unsigned COUNT_MAX = 65535;
   localparam int SETTLE_CYCLES = 80;
   localparam longint CYCLE_LIMIT = 1000000;

   typedef struct {
      logic [TAG_BITS-1:0]   tag;
      logic [COLOR_BITS-1:0] red, green, blue;
      logic [ALPHA_BITS-1:0] alpha;
   } ray_type;

   typedef struct {
      logic [OUT_COORD_BITS-1:0] x, y;
      logic [COLOR_BITS-1:0]     red, green, blue;
      logic [ALPHA_BITS-1:0]     alpha;
   } pixel_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic csr_wr_data = 0;
   logic req_valid = 0;
   logic req_stall;
   logic [TAG_BITS-1:0] req_ray_tag = '0;
   logic [COLOR_BITS-1:0] req_in_red = '0, req_in_green = '0, req_in_blue = '0;
   logic [ALPHA_BITS-1:0] req_in_alpha = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [OUT_COORD_BITS-1:0] rsp_out_x, rsp_out_y;
   logic [COLOR_BITS-1:0] rsp_out_red, rsp_out_green, rsp_out_blue;
   logic [ALPHA_BITS-1:0] rsp_out_alpha;

   pixel_sample_accumulator_top dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_ray_tag(req_ray_tag), .req_in_red(req_in_red), .req_in_green(req_in_green),
      .req_in_blue(req_in_blue), .req_in_alpha(req_in_alpha),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y), .rsp_out_red(rsp_out_red),
      .rsp_out_green(rsp_out_green), .rsp_out_blue(rsp_out_blue),
      .rsp_out_alpha(rsp_out_alpha)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // shadow pixel store
   bit [COLOR_BITS-1:0] shadow_red[STORE_DEPTH];
   bit [COLOR_BITS-1:0] shadow_green[STORE_DEPTH];
   bit [COLOR_BITS-1:0] shadow_blue[STORE_DEPTH];
   bit [ALPHA_BITS-1:0] shadow_alpha[STORE_DEPTH];
   bit [15:0]           shadow_count[STORE_DEPTH];
   bit                  shadow_claimed[STORE_DEPTH];
   bit                  transparent_on = 0;

   ray_type   ray_queue[$];
   pixel_type expected_pixels[$];
   int        error_count = 0;
   int        pixels_seen = 0;
   longint    cycle_count = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic longint unsigned running_mean(longint unsigned old, longint unsigned sample,
                                                    longint unsigned n);
      return (old * n + sample) / (n + 1);
   endfunction

   function automatic longint unsigned bumped_count(longint unsigned n);
      return (n + 1 > COUNT_MAX) ? COUNT_MAX : n + 1;
   endfunction

   task automatic accumulate_ray(input ray_type r);
      logic [19:0] x, y;
      logic [ALPHA_BITS-1:0] a;
      int idx;
      longint unsigned n, m;
      pixel_type p;
      x = r.tag[59:40];
      y = r.tag[39:20];
      if (x >= 256 || y >= 256) return;
      a = (r.alpha > ALPHA_ONE) ? ALPHA_ONE : r.alpha;
      idx = x * 256 + y;
      n = shadow_count[idx];
      if (transparent_on) begin
         if (a > ALPHA_HALF && !shadow_claimed[idx]) begin
            shadow_red[idx] = r.red;
            shadow_green[idx] = r.green;
            shadow_blue[idx] = r.blue;
            shadow_alpha[idx] = ALPHA_BITS'(65536 / (n + 1));
            shadow_claimed[idx] = 1;
            shadow_count[idx] = 16'(bumped_count(n));
            return;
         end
         if (a < ALPHA_HALF) begin
            if (shadow_claimed[idx])
               shadow_alpha[idx] = ALPHA_BITS'(running_mean(shadow_alpha[idx], a, n));
            shadow_count[idx] = 16'(bumped_count(n));
            return;
         end
      end
      shadow_red[idx] = COLOR_BITS'(running_mean(shadow_red[idx], r.red, n));
      shadow_green[idx] = COLOR_BITS'(running_mean(shadow_green[idx], r.green, n));
      shadow_blue[idx] = COLOR_BITS'(running_mean(shadow_blue[idx], r.blue, n));
      m = running_mean(shadow_alpha[idx], a, n);
      shadow_alpha[idx] = (m > ALPHA_ONE) ? ALPHA_ONE : ALPHA_BITS'(m);
      shadow_count[idx] = 16'(bumped_count(n));
      p.x = x[7:0];
      p.y = y[7:0];
      p.red = shadow_red[idx];
      p.green = shadow_green[idx];
      p.blue = shadow_blue[idx];
      p.alpha = shadow_alpha[idx];
      expected_pixels.push_back(p);
   endtask

   function automatic ray_type build_ray(logic [19:0] x, logic [19:0] y,
                                         logic [COLOR_BITS-1:0] c, logic [ALPHA_BITS-1:0] a);
      ray_type r;
      r.tag = {4'($urandom), x, y, 20'($urandom)};
      r.red = c;
      r.green = c ^ 24'h5a5a5a;
      r.blue = ~c;
      r.alpha = a;
      return r;
   endfunction

   function automatic ray_type random_ray();
      ray_type r;
      logic [19:0] x, y;
      int pick;
      pick = $urandom_range(99);
      // most traffic lands on a few hot pixels so the averages run deep
      if (pick < 75) begin
         x = 20'($urandom_range(3) * 85);
         y = 20'($urandom_range(3) * 85);
      end else if (pick < 93) begin
         x = 20'($urandom_range(255));
         y = 20'($urandom_range(255));
      end else begin
         x = 20'($urandom);
         y = 20'($urandom);
         if (x < 256 && y < 256) x[19] = 1'b1;
      end
      r.tag = {4'($urandom), x, y, 20'($urandom)};
      r.red = ($urandom_range(9) == 0) ? '1 : 24'($urandom);
      r.green = ($urandom_range(9) == 0) ? '0 : 24'($urandom);
      r.blue = 24'($urandom);
      case ($urandom_range(7))
         0: r.alpha = '0;
         1: r.alpha = ALPHA_HALF;
         2: r.alpha = ALPHA_ONE;
         3: r.alpha = 17'($urandom_range(131071, 65537));
         4: r.alpha = 17'($urandom_range(32767));
         default: r.alpha = 17'($urandom_range(65536));
      endcase
      return r;
   endfunction

   // driver: bursts of random length, gaps between them
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      ray_type r;
      logic next_valid;
      if (!reset && (!req_valid || !req_stall)) begin
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (ray_queue.size() > 0) begin
            r = ray_queue.pop_front();
            req_ray_tag <= r.tag;
            req_in_red <= r.red;
            req_in_green <= r.green;
            req_in_blue <= r.blue;
            req_in_alpha <= r.alpha;
            next_valid = 1'b1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(30);
               gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(60);
            end else begin
               burst_left--;
            end
         end
         req_valid <= next_valid;
      end
   end

   // receiver stall pattern, plus one long hold-off
   int stall_style = 0;
   int style_left = 0;
   int hold_left = 0;
   bit hold_done = 0;
   always @(posedge clock) begin
      if (!hold_done && pixels_seen == 100) begin
         hold_left = 600;
         hold_done = 1;
      end
      if (style_left == 0) begin
         stall_style = $urandom_range(2);
         style_left = $urandom_range(400, 50);
      end else begin
         style_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1;
      end else begin
         case (stall_style)
            0: rsp_stall <= 0;
            1: rsp_stall <= ($urandom_range(9) < 3);
            default: rsp_stall <= ($urandom_range(9) < 8);
         endcase
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      ray_type r;
      pixel_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("pixel_sample_accumulator_top_tb: errors");
         $finish;
      end
      if (!reset && req_valid && !req_stall) begin
         r.tag = req_ray_tag;
         r.red = req_in_red;
         r.green = req_in_green;
         r.blue = req_in_blue;
         r.alpha = req_in_alpha;
         accumulate_ray(r);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         pixels_seen++;
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected transaction x", rsp_out_x, 0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_out_x !== want.x) report_mismatch("x", rsp_out_x, want.x);
            if (rsp_out_y !== want.y) report_mismatch("y", rsp_out_y, want.y);
            if (rsp_out_red !== want.red) report_mismatch("red", rsp_out_red, want.red);
            if (rsp_out_green !== want.green)
               report_mismatch("green", rsp_out_green, want.green);
            if (rsp_out_blue !== want.blue) report_mismatch("blue", rsp_out_blue, want.blue);
            if (rsp_out_alpha !== want.alpha)
               report_mismatch("alpha", rsp_out_alpha, want.alpha);
         end
      end
   end

   task automatic drain_block();
      while (ray_queue.size() > 0 || req_valid || expected_pixels.size() > 0)
         @(posedge clock);
      // dropped or silent transactions may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input bit value);
      drain_block();
      csr_wr_en <= 1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 0;
      transparent_on = value;
   endtask

   task automatic queue_random(input int count);
      repeat (count) ray_queue.push_back(random_ray());
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // store sweep after reset
      while (req_stall) @(posedge clock);
      write_mode(0);

      ray_queue.push_back(build_ray(0, 0, '1, ALPHA_ONE));
      ray_queue.push_back(build_ray(0, 0, '0, '0));
      ray_queue.push_back(build_ray(0, 0, 24'h123456, 17'h1ffff));
      ray_queue.push_back(build_ray(255, 255, '1, ALPHA_HALF));
      ray_queue.push_back(build_ray(255, 0, 24'h800000, 17'h0ffff));
      ray_queue.push_back(build_ray(256, 3, '1, ALPHA_ONE));
      ray_queue.push_back(build_ray(3, 20'hfffff, '1, ALPHA_ONE));
      ray_queue.push_back(build_ray(20'hfffff, 20'hfffff, '1, ALPHA_ONE));
      ray_queue.push_back('{tag: '1, red: '1, green: '1, blue: '1, alpha: '1});
      ray_queue.push_back('{tag: '0, red: '0, green: '0, blue: '0, alpha: '0});
      write_mode(1);
      // claim, skip, alpha-only, exact half and claimed-opaque cases
      ray_queue.push_back(build_ray(10, 10, 24'hffffff, ALPHA_HALF + 1));
      ray_queue.push_back(build_ray(10, 10, 24'h000000, 17'h0));
      ray_queue.push_back(build_ray(10, 10, 24'h00ff00, ALPHA_HALF - 1));
      ray_queue.push_back(build_ray(10, 10, 24'h0000ff, ALPHA_HALF));
      ray_queue.push_back(build_ray(10, 10, 24'habcdef, ALPHA_ONE));
      ray_queue.push_back(build_ray(11, 0, 24'h111111, 17'h1));
      ray_queue.push_back(build_ray(11, 0, 24'h222222, ALPHA_HALF));
      ray_queue.push_back(build_ray(11, 0, 24'h333333, 17'h1ffff));
      ray_queue.push_back(build_ray(0, 0, 24'h444444, ALPHA_ONE));
      ray_queue.push_back(build_ray(255, 255, 24'h555555, 17'h0));
      queue_random(350);
      write_mode(0);
      queue_random(300);
      write_mode(1);
      queue_random(300);
      write_mode(0);
      queue_random(280);
      drain_block();

      if (error_count == 0 && expected_pixels.size() == 0) begin
         $display("pixel_sample_accumulator_top_tb: clean");
      end else begin
         $display("pixel_sample_accumulator_top_tb: errors");
      end
      $finish;
   end

endmodule
